// File: design/orb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_pkg
// Shared types, constants and helpers for the overwrite ring buffer.
// ----------------------------------------------------------------------------
package orb_pkg;

	localparam int DEPTH = 64;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int BYTE_W = 8;
	localparam int REQ_W = 7;
	localparam int LVL_W = 7;

	typedef enum logic [1:0] {
		OP_PUT       = 2'd0,
		OP_GET       = 2'd1,
		OP_BLOCK_GET = 2'd2,
		OP_CLEAR     = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [BYTE_W-1:0]   data_byte;
		logic [REQ_W-1:0]    max_count;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   read_byte;
		logic                byte_valid;
		logic                last;
		logic [LVL_W-1:0]    fill_level;
	} res_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_POP  = 1'b1
	} state_t;

	typedef struct packed {
		logic accept;
		logic put;
		logic clear;
		logic emit;
		logic load_one;
		logic load_n;
		logic pop;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic block_zero;
		logic last_pop;
	} dp_status_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// File: design/overwrite_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_buffer
// Byte FIFO in a circular store that drops the oldest byte when full.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Put, clear, a get on an
// empty store and a block get that pops nothing each give one result on the
// cycle after the word. A get or block get that pops n bytes holds busy high
// while it pops them, one store read per cycle, and the bytes follow one per
// cycle, each in the cycle after its read. Results are shown for exactly one
// cycle with res_valid high and must be taken then, since the receiver cannot
// stall the block.
module overwrite_ring_buffer import orb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic res_valid,
	output res_t res
);

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	orb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	orb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.res_valid (res_valid),
		.res       (res)
	);

	a_pop_gives_byte: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> (res_valid && res.byte_valid))
		else $error("pop did not produce a byte result");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> (res_valid || busy))
		else $error("accepted word produced neither a result nor a pop run");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.fill_level <= LVL_W'(DEPTH)))
		else $error("fill level above depth");

	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.byte_valid) |-> (res.last && res.read_byte == '0))
		else $error("non-byte result not marked last or not zero");

endmodule

// File: design/orb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module orb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/orb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_ctrl
// Controller: accepts words and sequences the pops of a get or block get.
// ----------------------------------------------------------------------------
module orb_ctrl import orb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cmd_t       cmd,
	input  dp_status_t sts,
	output ctrl_cmd_t  ctl,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					case (cmd.opcode)
						OP_PUT: begin
							ctl.put = 1'b1;
						end
						OP_GET: begin
							if (sts.empty) begin
								ctl.emit = 1'b1;
							end else begin
								ctl.load_one = 1'b1;
							end
						end
						OP_BLOCK_GET: begin
							if (sts.block_zero) begin
								ctl.emit = 1'b1;
							end else begin
								ctl.load_n = 1'b1;
							end
						end
						OP_CLEAR: begin
							ctl.clear = 1'b1;
						end
						default: begin
							ctl.emit = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				ctl.pop = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.load_one || ctl.load_n) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (sts.last_pop) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_POP);

endmodule

// File: design/orb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_dp
// Datapath: byte store, pointers, fill count, pop counter and result stage.
// ----------------------------------------------------------------------------
module orb_dp import orb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  ctrl_cmd_t  ctl,
	output dp_status_t sts,
	output logic       res_valid,
	output res_t       res
);

	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  remain_q;
	logic              out_valid_s1;
	logic              out_byte_s1;
	logic              out_last_s1;
	logic [CNT_W-1:0]  out_fill_s1;
	logic [BYTE_W-1:0] ram_rdata;
	logic              full;
	logic [CNT_W-1:0]  block_n;
	logic [CNT_W-1:0]  put_fill;

	assign full = (fill_q == CNT_W'(DEPTH));
	assign put_fill = full ? fill_q : fill_q + 1'b1;
	assign block_n = ({{CNT_W{1'b0}}, cmd.max_count} > {{REQ_W{1'b0}}, fill_q}) ?
		fill_q : CNT_W'(cmd.max_count);

	assign sts.empty = (fill_q == '0);
	assign sts.block_zero = (block_n == '0);
	assign sts.last_pop = (remain_q == CNT_W'(1));

	orb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ctl.put),
		.waddr (wr_ptr_q),
		.wdata (cmd.data_byte),
		.re    (ctl.pop),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q <= '0;
			remain_q <= '0;
		end else begin
			if (ctl.put) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
				fill_q <= put_fill;
				if (full) begin
					rd_ptr_q <= ptr_next(rd_ptr_q);
				end
			end else if (ctl.clear) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				fill_q <= '0;
			end else if (ctl.pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
				fill_q <= fill_q - 1'b1;
			end
			if (ctl.load_one) begin
				remain_q <= CNT_W'(1);
			end else if (ctl.load_n) begin
				remain_q <= block_n;
			end else if (ctl.pop) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else begin
			out_valid_s1 <= ctl.put || ctl.clear || ctl.emit || ctl.pop;
		end
	end

	always_ff @(posedge clk) begin
		out_byte_s1 <= ctl.pop;
		out_last_s1 <= !ctl.pop || (remain_q == CNT_W'(1));
		if (ctl.put) begin
			out_fill_s1 <= put_fill;
		end else if (ctl.clear) begin
			out_fill_s1 <= '0;
		end else if (ctl.pop) begin
			out_fill_s1 <= fill_q - 1'b1;
		end else begin
			out_fill_s1 <= fill_q;
		end
	end

	assign res_valid = out_valid_s1;
	assign res.read_byte = out_byte_s1 ? ram_rdata : '0;
	assign res.byte_valid = out_byte_s1;
	assign res.last = out_last_s1;
	assign res.fill_level = LVL_W'(out_fill_s1);

endmodule

// File: tb/sv/overwrite_ring_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_buffer_tb
// Self-checking bench for the overwrite ring buffer. A directed table covers
// empty reads, zero and oversized block counts, overwrite on full and clear.
// Random words with random sender gaps follow. Every result is checked against
// a local model of the FIFO, or the fixed result of a pinned table step.
// ----------------------------------------------------------------------------
module overwrite_ring_buffer_tb;
	import orb_pkg::*;

	localparam int IDLE_LIMIT = 500;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_WORDS = 60;

	typedef struct {
		opcode_t          op;
		logic [BYTE_W-1:0] data;
		logic [REQ_W-1:0]  count;
		int               reps;
		bit               pinned;
		res_t             want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic res_valid;
	res_t res;

	logic pin_on;
	res_t pin_res;

	logic [BYTE_W-1:0] fifo_mem [DEPTH];
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] wr_ptr;
	logic [LVL_W-1:0] fill_lvl;

	res_t pending_res [$];
	step_t plan [$];
	int errors;
	int idle_cycles;
	bit no_idle;

	overwrite_ring_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.res_valid(res_valid),
		.res(res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic res_t mk_res(input logic [BYTE_W-1:0] b, input logic v,
		input logic l, input logic [LVL_W-1:0] lv);
		res_t r;
		r.read_byte = b;
		r.byte_valid = v;
		r.last = l;
		r.fill_level = lv;
		return r;
	endfunction

	task automatic pop_byte(input logic l);
		logic [BYTE_W-1:0] b;
		b = fifo_mem[rd_ptr];
		rd_ptr = rd_ptr + 1'b1;
		fill_lvl = fill_lvl - 1'b1;
		pending_res.push_back(mk_res(b, 1'b1, l, fill_lvl));
	endtask

	task automatic predict_word(input cmd_t c);
		int n;
		case (c.opcode)
			OP_PUT: begin
				if (fill_lvl == LVL_W'(DEPTH)) begin
					rd_ptr = rd_ptr + 1'b1;
					fill_lvl = fill_lvl - 1'b1;
				end
				fifo_mem[wr_ptr] = c.data_byte;
				wr_ptr = wr_ptr + 1'b1;
				fill_lvl = fill_lvl + 1'b1;
				pending_res.push_back(mk_res('0, 1'b0, 1'b1, fill_lvl));
			end
			OP_GET: begin
				if (fill_lvl == 0)
					pending_res.push_back(mk_res('0, 1'b0, 1'b1, fill_lvl));
				else
					pop_byte(1'b1);
			end
			OP_BLOCK_GET: begin
				n = c.max_count;
				if (n > fill_lvl)
					n = fill_lvl;
				if (n > DEPTH)
					n = DEPTH;
				if (n == 0)
					pending_res.push_back(mk_res('0, 1'b0, 1'b1, fill_lvl));
				for (int i = 0; i < n; i++)
					pop_byte(i == n - 1);
			end
			default: begin
				rd_ptr = '0;
				wr_ptr = '0;
				fill_lvl = '0;
				pending_res.push_back(mk_res('0, 1'b0, 1'b1, fill_lvl));
			end
		endcase
	endtask

	task automatic report_field(input string name, input int want, input int got);
		if (errors < 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
		errors++;
	endtask

	always @(posedge clk) begin : check_proc
		res_t want;
		if (arst_n) begin
			if (res_valid) begin
				if (pending_res.size() == 0) begin
					report_field("unexpected word, read_byte", 0, res.read_byte);
				end else begin
					want = pending_res.pop_front();
					if (res.read_byte !== want.read_byte)
						report_field("read_byte", want.read_byte, res.read_byte);
					if (res.byte_valid !== want.byte_valid)
						report_field("byte_valid", want.byte_valid, res.byte_valid);
					if (res.last !== want.last)
						report_field("last", want.last, res.last);
					if (res.fill_level !== want.fill_level)
						report_field("fill_level", want.fill_level, res.fill_level);
				end
			end
			if (start && !busy) begin
				predict_word(cmd);
				if (pin_on)
					pending_res[pending_res.size() - 1] = pin_res;
			end
			if (res_valid || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		if ($urandom_range(0, 14) == 0)
			no_idle = !no_idle;
		return no_idle ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic issue(input cmd_t c, input bit pin, input res_t pres, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		pin_on <= pin;
		pin_res <= pres;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_step(input opcode_t op, input logic [BYTE_W-1:0] data,
		input logic [REQ_W-1:0] count, input int reps, input bit pinned, input res_t want);
		step_t s;
		s.op = op;
		s.data = data;
		s.count = count;
		s.reps = reps;
		s.pinned = pinned;
		s.want = want;
		plan.push_back(s);
	endtask

	initial begin
		cmd_t c;
		int pick;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		pin_on = 1'b0;
		pin_res = '0;
		rd_ptr = '0;
		wr_ptr = '0;
		fill_lvl = '0;
		errors = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			fifo_mem[i] = '0;

		add_step(OP_GET, 8'h00, 7'd0, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd0));
		add_step(OP_BLOCK_GET, 8'h00, 7'd64, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd0));
		add_step(OP_CLEAR, 8'h00, 7'd0, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd0));
		add_step(OP_PUT, 8'h00, 7'd0, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd1));
		add_step(OP_PUT, 8'hFF, 7'd127, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd2));
		add_step(OP_BLOCK_GET, 8'hFF, 7'd0, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd2));
		add_step(OP_GET, 8'h00, 7'd0, 1, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 7'd1));
		add_step(OP_GET, 8'h00, 7'd0, 1, 1'b1, mk_res(8'hFF, 1'b1, 1'b1, 7'd0));
		add_step(OP_PUT, 8'h3C, 7'd0, 5, 1'b0, '0);
		add_step(OP_BLOCK_GET, 8'h00, 7'd127, 1, 1'b0, '0);
		add_step(OP_PUT, 8'h80, 7'd0, DEPTH + 2, 1'b0, '0);
		add_step(OP_PUT, 8'h01, 7'd0, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd64));
		add_step(OP_BLOCK_GET, 8'h00, 7'd64, 1, 1'b0, '0);
		add_step(OP_PUT, 8'h55, 7'd0, 10, 1'b0, '0);
		add_step(OP_BLOCK_GET, 8'h00, 7'd3, 1, 1'b0, '0);
		add_step(OP_CLEAR, 8'hFF, 7'd127, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd0));
		add_step(OP_GET, 8'h00, 7'd0, 1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 7'd0));
		add_step(OP_PUT, 8'hAA, 7'd0, 6, 1'b0, '0);
		add_step(OP_BLOCK_GET, 8'h00, 7'd100, 1, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				c.opcode = plan[i].op;
				c.data_byte = plan[i].data + BYTE_W'(k);
				c.max_count = plan[i].count;
				issue(c, plan[i].pinned, plan[i].want, draw_gap());
			end
		end

		start <= 1'b0;
		wait_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 19) == 0) begin
				start <= 1'b0;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			c.data_byte = BYTE_W'($urandom_range(0, 255));
			c.max_count = ($urandom_range(0, 4) == 0) ? REQ_W'($urandom_range(0, 127))
				: REQ_W'($urandom_range(0, 12));
			if (pick < 45)
				c.opcode = OP_PUT;
			else if (pick < 65)
				c.opcode = OP_GET;
			else if (pick < 93)
				c.opcode = OP_BLOCK_GET;
			else
				c.opcode = OP_CLEAR;
			issue(c, 1'b0, '0, draw_gap());
		end

		start <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		errors += pending_res.size();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
